>>> rtl/dlsf_pkg.sv
// Shared types, codes, constants and a helper function of the LED scan framer.
`timescale 1ns / 1ps
`default_nettype none
package dlsf_pkg;

  localparam int unsigned PeriodW = 15;
  localparam logic [PeriodW-1:0] PeriodReset = 15'd500;
  localparam int unsigned NumDigits = 6;
  localparam int unsigned NumVleds = 4;
  localparam int unsigned NumHleds = 8;
  localparam int unsigned NumPhases = 3;

  // Strobe patterns per phase for each common polarity.
  localparam logic [7:0] StrobeSingle [NumPhases] = '{8'h40, 8'h20, 8'h80};
  localparam logic [7:0] StrobePair [NumPhases] = '{8'hA0, 8'hC0, 8'h60};

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_WR_SEG    = 3'd1,
    CMD_WR_BLINK  = 3'd2,
    CMD_WR_VLED   = 3'd3,
    CMD_WR_HLED   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_LED_PERIOD   = 2'd0,
    CFG_DIGIT_PERIOD = 2'd1,
    CFG_POLARITY     = 2'd2
  } cfg_idx_e;

  localparam logic [1:0] LedBlink = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tick;
    logic wr_seg;
    logic wr_blink;
    logic wr_vled;
    logic wr_hled;
    logic cfg_we;
  } dlsf_ctl_t;

  function automatic logic led_lit(input logic [1:0] st, input logic blink);
    logic lit;
    if (st == LedBlink) lit = blink;
    else lit = st[0];
    return lit;
  endfunction

endpackage
`default_nettype wire

>>> rtl/dlsf_ctrl.sv
// Controller state machine of the LED scan framer: decodes items, times results.
`timescale 1ns / 1ps
`default_nettype none
module dlsf_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [2:0]           command_i,
  input  wire logic                 cfg_valid_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic                      cfg_ready_o,
  output dlsf_pkg::dlsf_ctl_t       ctl_o
);
  import dlsf_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SHOW
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;
  logic   accept;
  logic   cfg_ready;

  assign accept = start_i && !busy_q;
  // Hold configuration off while an item is offered or a result is pending.
  assign cfg_ready = !busy_q && !start_i;

  always_comb begin
    ctl_o = '0;
    ctl_o.cfg_we = cfg_valid_i && cfg_ready;
    if (accept) begin
      unique case (command_i)
        CMD_TICK:     ctl_o.tick = 1'b1;
        CMD_WR_SEG:   ctl_o.wr_seg = 1'b1;
        CMD_WR_BLINK: ctl_o.wr_blink = 1'b1;
        CMD_WR_VLED:  ctl_o.wr_vled = 1'b1;
        CMD_WR_HLED:  ctl_o.wr_hled = 1'b1;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (ctl_o.tick) begin
            state_q <= S_SHOW;
            busy_q  <= 1'b1;
            done_q  <= 1'b1;
          end
        end
        S_SHOW: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign cfg_ready_o = cfg_ready;

endmodule
`default_nettype wire

>>> rtl/dlsf_datapath.sv
// Datapath of the LED scan framer: display stores, blink counters, frame builder.
`timescale 1ns / 1ps
`default_nettype none
module dlsf_datapath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  dlsf_pkg::dlsf_ctl_t        ctl_i,
  input  wire logic [2:0]            index_i,
  input  wire logic [7:0]            value_i,
  input  wire logic [7:0]            rx_byte_i,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [14:0]           cfg_data_i,
  output logic [7:0]                 frame_byte0_o,
  output logic [7:0]                 frame_byte1_o,
  output logic [7:0]                 frame_byte2_o,
  output logic [7:0]                 frame_byte3_o,
  output logic [5:0]                 keys_o
);
  import dlsf_pkg::*;

  logic [7:0]         seg_q   [NumDigits];
  logic [NumDigits-1:0] dblink_flag_q;
  logic [1:0]         vled_q  [NumVleds];
  logic [1:0]         hled_q  [NumHleds];
  logic [1:0]         phase_q;
  logic [PeriodW-1:0] led_period_q, dig_period_q;
  logic [PeriodW-1:0] led_cnt_q, dig_cnt_q;
  logic               polarity_q;

  logic [1:0]         ph;
  logic [2:0]         lo_idx, hi_idx;
  logic               lblink, dblink;
  logic [3:0]         vmask;
  logic [7:0]         hmask;
  logic [7:0]         strobe;
  logic [PeriodW-1:0] led_cnt_d, dig_cnt_d;

  always_comb begin
    ph = (phase_q > 2'd2) ? 2'd0 : phase_q;
    lo_idx = {1'b0, ph};
    hi_idx = {1'b0, ph} + 3'd3;
    lblink = (led_period_q == '0) || (led_cnt_q <= (led_period_q >> 1));
    dblink = (dig_period_q != '0) && (dig_cnt_q <= (dig_period_q >> 1));
    for (int i = 0; i < NumVleds; i++) begin
      vmask[NumVleds-1-i] = led_lit(vled_q[i], lblink);
    end
    for (int i = 0; i < NumHleds; i++) begin
      hmask[i] = led_lit(hled_q[i], lblink);
    end
    strobe = polarity_q ? StrobePair[ph] : StrobeSingle[ph];
    if (led_period_q == '0) led_cnt_d = '0;
    else if (led_cnt_q <= 15'd1) led_cnt_d = led_period_q;
    else led_cnt_d = led_cnt_q - 15'd1;
    if (dig_period_q == '0) dig_cnt_d = '0;
    else if (dig_cnt_q <= 15'd1) dig_cnt_d = dig_period_q;
    else dig_cnt_d = dig_cnt_q - 15'd1;
  end

  // Control state: stores, phase, counters and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumDigits; i++) seg_q[i] <= '0;
      for (int i = 0; i < NumVleds; i++) vled_q[i] <= '0;
      for (int i = 0; i < NumHleds; i++) hled_q[i] <= '0;
      dblink_flag_q <= '0;
      phase_q      <= '0;
      led_period_q <= PeriodReset;
      dig_period_q <= PeriodReset;
      led_cnt_q    <= PeriodReset;
      dig_cnt_q    <= PeriodReset;
      polarity_q   <= 1'b0;
    end else begin
      if (ctl_i.wr_seg && index_i < 3'(NumDigits)) seg_q[index_i] <= value_i;
      if (ctl_i.wr_blink && index_i < 3'(NumDigits)) dblink_flag_q[index_i] <= value_i[0];
      if (ctl_i.wr_vled && index_i < 3'(NumVleds)) vled_q[index_i[1:0]] <= value_i[1:0];
      if (ctl_i.wr_hled) hled_q[index_i] <= value_i[1:0];
      if (ctl_i.tick) begin
        phase_q   <= (ph == 2'd2) ? 2'd0 : ph + 2'd1;
        led_cnt_q <= led_cnt_d;
        dig_cnt_q <= dig_cnt_d;
      end
      if (ctl_i.cfg_we) begin
        unique case (cfg_index_i)
          CFG_LED_PERIOD: begin
            led_period_q <= cfg_data_i;
            led_cnt_q    <= cfg_data_i;
          end
          CFG_DIGIT_PERIOD: begin
            dig_period_q <= cfg_data_i;
            dig_cnt_q    <= cfg_data_i;
          end
          CFG_POLARITY: polarity_q <= cfg_data_i[0];
          default: polarity_q <= polarity_q;
        endcase
      end
    end
  end

  // Result registers: hold the frame of the last tick.
  always_ff @(posedge clk_i) begin
    if (ctl_i.tick) begin
      frame_byte0_o <= (dblink_flag_q[hi_idx] && dblink) ? 8'd0 : seg_q[hi_idx];
      frame_byte1_o <= ~{hmask[7:4], hmask[2:0], hmask[3]};
      frame_byte2_o <= (dblink_flag_q[lo_idx] && dblink) ? 8'd0 : seg_q[lo_idx];
      frame_byte3_o <= {3'b000, ~vmask, 1'b0} | strobe;
      keys_o        <= {rx_byte_i[7:5], rx_byte_i[2:0]};
    end
  end

endmodule
`default_nettype wire

>>> rtl/display_led_scan_framer.sv
// Top level of the six-digit, twelve-LED display scan framer.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Items enter on start_i while busy_o is low: command_i, index_i, value_i
//   and rx_byte_i. Write commands (digit segments, digit blink flag,
//   vertical or horizontal LED state) take effect at the accepting edge,
//   produce no result and leave busy_o low, so a new item can follow in
//   the next cycle. Unknown commands are dropped.
//   A tick builds the four-byte frame for the current scan phase, decodes
//   the key bits of rx_byte_i, then advances the phase and both blink
//   counters. Its result shows on frame_byte0_o..frame_byte3_o and keys_o
//   for exactly one cycle, marked by done_o, in the cycle after the tick
//   is accepted; busy_o is high during that cycle, while the controller is in
//   its result state S_SHOW; a write does not enter that state.
//   The receiver cannot stall: it must take the result while done_o is high.
//   Configuration writes (blink periods, common polarity) use cfg_valid_i,
//   cfg_ready_o, cfg_index_i and cfg_data_i; cfg_ready_o is low while busy_o
//   or start_i is high. A period write reloads its counter; index 3 is ignored.
//   Reset clears all stores, the phase and the polarity, and loads both
//   periods and counters with 500 ticks.
module display_led_scan_framer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [2:0]  index_i,
  input  wire logic [7:0]  value_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             done_o,
  output logic [7:0]       frame_byte0_o,
  output logic [7:0]       frame_byte1_o,
  output logic [7:0]       frame_byte2_o,
  output logic [7:0]       frame_byte3_o,
  output logic [5:0]       keys_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [14:0] cfg_data_i
);
  import dlsf_pkg::*;

  // Commands from the controller into the datapath.
  dlsf_ctl_t ctl;

  dlsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .command_i   (command_i),
    .cfg_valid_i (cfg_valid_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .cfg_ready_o (cfg_ready_o),
    .ctl_o       (ctl)
  );

  dlsf_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .index_i       (index_i),
    .value_i       (value_i),
    .rx_byte_i     (rx_byte_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .frame_byte0_o (frame_byte0_o),
    .frame_byte1_o (frame_byte1_o),
    .frame_byte2_o (frame_byte2_o),
    .frame_byte3_o (frame_byte3_o),
    .keys_o        (keys_o)
  );

endmodule
`default_nettype wire
